>>> hdl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types and constants for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

   localparam int ROUNDS       = 80;
   localparam int ROUND_W      = 7;
   localparam int DIGEST_WORDS = 5;
   localparam int IDX_W        = 3;
   localparam int BLOCK_BYTES  = 64;
   localparam int POS_W        = 6;
   localparam int CNT_W        = 61;

   localparam logic [31:0] IV_INIT [DIGEST_WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [ROUND_W-1:0] ROUND_LAST = 7'(ROUNDS - 1);
   localparam logic [ROUND_W-1:0] ROUND_B1   = 7'd20;
   localparam logic [ROUND_W-1:0] ROUND_B2   = 7'd40;
   localparam logic [ROUND_W-1:0] ROUND_B3   = 7'd60;

   localparam logic [7:0]       PAD_BYTE  = 8'h80;
   localparam logic [POS_W-1:0] LEN_POS   = 6'd56;
   localparam logic [POS_W-1:0] BLOCK_END = 6'(BLOCK_BYTES - 1);

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } sha1_work_type;

   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] data;
   } sha1_buf_ctrl_type;

endpackage

>>> hdl/sha1_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 round unit
// One compression round, shared across all 80 rounds of a block.
// ----------------------------------------------------------------------------
module sha1_round (
   input  sha1_pkg::sha1_work_type       work_cur,
   input  logic [31:0]                   sched_word,
   input  logic [sha1_pkg::ROUND_W-1:0]  round_idx,
   output sha1_pkg::sha1_work_type       work_nxt
);
   import sha1_pkg::*;

   logic [31:0] f_val;
   logic [31:0] k_val;

   always_comb begin
      priority if (round_idx < ROUND_B1) begin
         f_val = (work_cur.b & work_cur.c) | (~work_cur.b & work_cur.d);
         k_val = K_0;
      end else if (round_idx < ROUND_B2) begin
         f_val = work_cur.b ^ work_cur.c ^ work_cur.d;
         k_val = K_1;
      end else if (round_idx < ROUND_B3) begin
         f_val = (work_cur.b & work_cur.c) | (work_cur.b & work_cur.d) |
                 (work_cur.c & work_cur.d);
         k_val = K_2;
      end else begin
         f_val = work_cur.b ^ work_cur.c ^ work_cur.d;
         k_val = K_3;
      end
   end

   always_comb begin
      work_nxt.a = {work_cur.a[26:0], work_cur.a[31:27]} + f_val + work_cur.e +
                   sched_word + k_val;
      work_nxt.b = work_cur.a;
      work_nxt.c = {work_cur.b[1:0], work_cur.b[31:2]};
      work_nxt.d = work_cur.c;
      work_nxt.e = work_cur.d;
   end

endmodule

>>> hdl/sha1_msg_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message buffer
// Block shift line that collects bytes and expands the message schedule.
// ----------------------------------------------------------------------------
module sha1_msg_buf (
   input  logic                         clock,
   input  sha1_pkg::sha1_buf_ctrl_type  ctrl,
   output logic [31:0]                  sched_word
);
   import sha1_pkg::*;

   logic [8*BLOCK_BYTES-1:0] line_ff;
   logic [8*BLOCK_BYTES-1:0] line_in;
   logic [31:0]              w_0;
   logic [31:0]              w_2;
   logic [31:0]              w_8;
   logic [31:0]              w_13;
   logic [31:0]              mix;

   assign w_0  = line_ff[8*BLOCK_BYTES-1        -: 32];
   assign w_2  = line_ff[8*BLOCK_BYTES-1 - 2*32  -: 32];
   assign w_8  = line_ff[8*BLOCK_BYTES-1 - 8*32  -: 32];
   assign w_13 = line_ff[8*BLOCK_BYTES-1 - 13*32 -: 32];
   assign mix  = w_13 ^ w_8 ^ w_2 ^ w_0;
   assign sched_word = w_0;

   always_comb begin
      line_in = line_ff;
      if (ctrl.shift_byte) begin
         line_in = {line_ff[8*BLOCK_BYTES-9:0], ctrl.data};
      end else if (ctrl.shift_word) begin
         line_in = {line_ff[8*BLOCK_BYTES-33:0], mix[30:0], mix[31]};
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

endmodule

>>> hdl/sha1_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Absorbs one message byte per word and emits the five digest words on finish.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake         Payload
//   req      in         req_valid/stall   req_operation, req_data_byte
//   rsp      out        rsp_valid/stall   rsp_digest_word, rsp_word_index,
//                                         rsp_last_word
//
// An absorb word that completes a block then runs the shared round unit
// through 80 rounds and one chaining add.
// A finish word feeds padding bytes at one per cycle, compresses once or
// twice, and then offers five digest words.
// Reset is synchronous and returns the chaining value and length to start.
// A stalled digest word holds; no new word is taken until the last is taken.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha1_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PAD  = 3'd1;
   localparam logic [2:0] ST_COMP = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [IDX_W-1:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

   logic [2:0]         state_ff,  state_in;
   logic [ROUND_W-1:0] round_ff,  round_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [63:0]        len_ff,    len_in;
   logic               fin_ff,    fin_in;
   logic               first_ff,  first_in;
   logic               wrap_ff,   wrap_in;
   logic               done_ff,   done_in;
   logic [IDX_W-1:0]   idx_ff,    idx_in;
   logic [31:0]        chain_ff [DIGEST_WORDS];
   logic [31:0]        chain_in [DIGEST_WORDS];
   sha1_work_type      work_ff,   work_in;

   sha1_work_type      round_out;
   sha1_work_type      chain_work;
   sha1_buf_ctrl_type  buf_ctrl;
   logic [31:0]        sched_word;
   logic [POS_W-1:0]   pos;
   logic [5:0]         len_lsb;
   logic [7:0]         len_byte;

   sha1_msg_buf u_msg_buf (
      .clock      (clock),
      .ctrl       (buf_ctrl),
      .sched_word (sched_word)
   );

   sha1_round u_round (
      .work_cur   (work_ff),
      .sched_word (sched_word),
      .round_idx  (round_ff),
      .work_nxt   (round_out)
   );

   assign pos      = cnt_ff[POS_W-1:0];
   assign len_lsb  = {~pos[2:0], 3'b000};
   assign len_byte = len_ff[len_lsb +: 8];

   assign chain_work = '{a: chain_ff[0], b: chain_ff[1], c: chain_ff[2],
                         d: chain_ff[3], e: chain_ff[4]};

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == IDX_LAST);

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      fin_in   = fin_ff;
      first_in = first_ff;
      wrap_in  = wrap_ff;
      done_in  = done_ff;
      idx_in   = idx_ff;
      work_in  = work_ff;
      chain_in = chain_ff;
      buf_ctrl = '{shift_byte: 1'b0, shift_word: 1'b0, data: req_data_byte};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation) begin
                  len_in   = {cnt_ff, 3'b000};
                  fin_in   = 1'b1;
                  first_in = 1'b1;
                  wrap_in  = 1'b0;
                  done_in  = 1'b0;
                  state_in = ST_PAD;
               end else begin
                  buf_ctrl.shift_byte = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  if (pos == BLOCK_END) begin
                     state_in = ST_COMP;
                     round_in = '0;
                     work_in  = chain_work;
                  end
               end
            end
         end
         ST_PAD: begin
            buf_ctrl.shift_byte = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            first_in = 1'b0;
            if (first_ff) begin
               buf_ctrl.data = PAD_BYTE;
               wrap_in = (pos >= LEN_POS);
            end else if ((pos >= LEN_POS) && !wrap_ff) begin
               buf_ctrl.data = len_byte;
               done_in = (pos == BLOCK_END);
            end else begin
               buf_ctrl.data = 8'h00;
            end
            if (pos == BLOCK_END) begin
               wrap_in  = 1'b0;
               state_in = ST_COMP;
               round_in = '0;
               work_in  = chain_work;
            end
         end
         ST_COMP: begin
            buf_ctrl.shift_word = 1'b1;
            work_in  = round_out;
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + work_ff.a;
            chain_in[1] = chain_ff[1] + work_ff.b;
            chain_in[2] = chain_ff[2] + work_ff.c;
            chain_in[3] = chain_ff[3] + work_ff.d;
            chain_in[4] = chain_ff[4] + work_ff.e;
            idx_in = '0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (done_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
                  chain_in = IV_INIT;
                  cnt_in   = '0;
                  fin_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         first_ff <= 1'b0;
         wrap_ff  <= 1'b0;
         done_ff  <= 1'b0;
         idx_ff   <= '0;
         chain_ff <= IV_INIT;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         first_ff <= first_in;
         wrap_ff  <= wrap_in;
         done_ff  <= done_in;
         idx_ff   <= idx_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      work_ff <= work_in;
   end

   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP) |-> (round_ff <= ROUND_LAST))
      else $error("Round counter ran past the last round.");

   a_comp_to_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMP && round_ff == ROUND_LAST) |=> (state_ff == ST_FOLD))
      else $error("Compression did not end in the chaining add.");

   a_block_full: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_operation && pos == BLOCK_END)
      |=> (state_ff == ST_COMP && round_ff == '0))
      else $error("A full block did not start compression.");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_word)
      |=> (state_ff == ST_IDLE && cnt_ff == '0 && !fin_ff))
      else $error("Engine did not restart after the last digest word.");

   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (fin_ff && done_ff))
      else $error("Digest offered before the length was absorbed.");

endmodule

>>> dv/sha1_hash_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine testbench
// Sends message bytes and finish words to the engine and checks every digest
// word against a bit-exact SHA-1 predictor kept in this file. A short table
// covers the empty message, repeated finishes, "abc" and the byte extremes.
// Random messages follow, many of them near the block and padding edges.
// Both sides idle at random, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb;

   import sha1_pkg::*;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int RESET_CYCLES       = 8;
   localparam int RANDOM_ITEMS       = 195;
   localparam int PRESSURE_CYCLES    = 600;
   localparam int DRAIN_CYCLES       = 300;
   localparam int WATCHDOG_LIMIT     = 4000;

   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

   localparam int EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

   typedef struct packed {
      logic         op;
      logic [7:0]   data;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   typedef struct packed {
      logic [31:0]      word;
      logic [IDX_W-1:0] index;
      logic             last;
   } digest_word_type;

   localparam int DIRECTED_COUNT = 14;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      '{OP_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},
      '{OP_ABSORB, 8'h61, 1'b0, 160'd0},
      '{OP_ABSORB, 8'h62, 1'b0, 160'd0},
      '{OP_ABSORB, 8'h63, 1'b0, 160'd0},
      '{OP_FINISH, 8'h00, 1'b1, ABC_DIGEST},
      '{OP_ABSORB, 8'h00, 1'b0, 160'd0},
      '{OP_ABSORB, 8'hFF, 1'b0, 160'd0},
      '{OP_ABSORB, 8'h80, 1'b0, 160'd0},
      '{OP_ABSORB, 8'h7F, 1'b0, 160'd0},
      '{OP_FINISH, 8'hFF, 1'b0, 160'd0},
      '{OP_ABSORB, 8'hAA, 1'b0, 160'd0},
      '{OP_ABSORB, 8'h55, 1'b0, 160'd0},
      '{OP_FINISH, 8'h5A, 1'b0, 160'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_operation = OP_ABSORB;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b1;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   logic         req_has_digest = 1'b0;
   logic [159:0] req_known_digest = '0;

   logic [31:0] chain_words [DIGEST_WORDS];
   logic [7:0]  block_bytes [BLOCK_BYTES];
   logic [63:0] length_bits;

   digest_word_type digest_words_q [$];

   int fail_count      = 0;
   int words_accepted  = 0;
   int digests_started = 0;
   int words_checked   = 0;
   int idle_cycles     = 0;
   bit pressure_done   = 1'b0;

   sha1_hash_engine i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void sha1_restart();
      for (int i = 0; i < DIGEST_WORDS; i++) chain_words[i] = IV_INIT[i];
      length_bits = '0;
   endfunction

   function automatic void sha1_compress();
      logic [31:0] w [ROUNDS];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int r = 0; r < 16; r++) begin
         w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
      end
      for (int r = 16; r < ROUNDS; r++) begin
         w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int r = 0; r < ROUNDS; r++) begin
         if (r < int'(ROUND_B1)) begin
            f = (b & c) | (~b & d);
            k = K_0;
         end else if (r < int'(ROUND_B2)) begin
            f = b ^ c ^ d;
            k = K_1;
         end else if (r < int'(ROUND_B3)) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_2;
         end else begin
            f = b ^ c ^ d;
            k = K_3;
         end
         t = rotl(a, 5) + f + e + w[r] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endfunction

   function automatic void sha1_absorb(input logic [7:0] data);
      logic [POS_W-1:0] pos;
      pos = length_bits[POS_W+2:3];
      block_bytes[pos] = data;
      length_bits += 64'd8;
      if (pos == BLOCK_END) sha1_compress();
   endfunction

   function automatic logic [159:0] sha1_finish();
      logic [63:0]  length;
      logic [159:0] digest;
      length = length_bits;
      sha1_absorb(PAD_BYTE);
      while (length_bits[POS_W+2:3] != LEN_POS) sha1_absorb(8'h00);
      for (int i = 0; i < 8; i++) sha1_absorb(length[63-8*i -: 8]);
      digest = {chain_words[0], chain_words[1], chain_words[2], chain_words[3], chain_words[4]};
      sha1_restart();
      return digest;
   endfunction

   initial begin
      sha1_restart();
      for (int i = 0; i < BLOCK_BYTES; i++) block_bytes[i] = 8'h00;
   end

   always @(posedge clock) begin
      logic [159:0] digest;
      digest_word_type expected;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            words_accepted++;
            if (req_operation == OP_ABSORB) begin
               sha1_absorb(req_data_byte);
            end else begin
               digest = sha1_finish();
               if (req_has_digest) digest = req_known_digest;
               for (int i = 0; i < DIGEST_WORDS; i++) begin
                  digest_words_q.push_back('{digest[159-32*i -: 32], IDX_W'(i),
                                            i == DIGEST_WORDS - 1});
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (digest_words_q.size() == 0) begin
               $error("unexpected digest word %h at index %0d", rsp_digest_word, rsp_word_index);
               fail_count++;
            end else begin
               expected = digest_words_q.pop_front();
               if (rsp_digest_word !== expected.word) begin
                  $error("digest_word: expected %h, got %h", expected.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== expected.index) begin
                  $error("word_index: expected %0d, got %0d", expected.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== expected.last) begin
                  $error("last_word: expected %0b, got %0b", expected.last, rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sha1_hash_engine_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return $urandom_range(0, 10);
      if (roll < 90) return EDGE_LENGTHS[$urandom_range(0, 5)];
      return $urandom_range(66, 130);
   endfunction

   task automatic send_word(input logic op, input logic [7:0] data, input logic known,
                            input logic [159:0] digest, input int gap);
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_data_byte    <= data;
      req_has_digest   <= known;
      req_known_digest <= digest;
      do @(posedge clock); while (req_stall);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int  span;
      bit  stall_next;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!pressure_done && words_checked >= 20 && rsp_valid) begin
            stall_next    = 1'b1;
            span          = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            stall_next = 1'b0;
            span       = $urandom_range(20, 60);
         end else begin
            stall_next = ($urandom_range(0, 99) >= 65);
            span       = stall_next ? pick_gap() + 1 : $urandom_range(1, 8);
         end
         rsp_stall <= stall_next;
         repeat (span) @(posedge clock);
      end
   end

   initial begin
      int  len;
      int  items_sent;
      bit  burst;
      items_sent = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].known,
                   DIRECTED_ROWS[i].digest, pick_gap());
         if (DIRECTED_ROWS[i].op == OP_FINISH) digests_started++;
      end

      while (items_sent < RANDOM_ITEMS) begin
         len   = pick_length();
         if (len > RANDOM_ITEMS - items_sent - 1) len = RANDOM_ITEMS - items_sent - 1;
         burst = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < len; n++) begin
            send_word(OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, '0, burst ? 0 : pick_gap());
            items_sent++;
         end
         send_word(OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0, burst ? 0 : pick_gap());
         items_sent++;
         digests_started++;
      end
      req_valid <= 1'b0;
      @(posedge clock);

      while (digest_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Accepted %0d input words and checked %0d digest words from %0d messages,",
               words_accepted, words_checked, digests_started);
      $display("with block-edge lengths, multi-block messages and a long output hold-off.");
      if (fail_count == 0) begin
         $display("sha1_hash_engine_tb OK");
      end else begin
         $display("sha1_hash_engine_tb NOT OK");
      end
      $finish;
   end

endmodule
